[hdl/ssba_pkg.sv]
package ssba_pkg;

  localparam int unsigned MAX_BINS = 64;
  localparam int unsigned BIN_AW   = $clog2(MAX_BINS);
  localparam int unsigned CNT_W    = BIN_AW + 1;
  localparam int unsigned APB_AW   = 4;

  localparam logic signed [7:0] SAT_HI  = 8'sd127;
  localparam logic signed [7:0] SAT_LO  = -8'sd128;
  localparam logic signed [7:0] AMT_MIN = -8'sd127;

  // register word indexes
  localparam logic [1:0] REG_NUM_BINS   = 2'd0;
  localparam logic [1:0] REG_INIT_VALUE = 2'd1;
  localparam logic [1:0] REG_MIN_SCORE  = 2'd2;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ADD,
    MODE_SUB
  } mode_e;

  typedef struct packed {
    logic load_item;
    logic clear_bank;
    logic check_rd;
    logic set_add;
    logic set_sub;
    logic start_pass;
    logic pass_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic in_range;
    logic at_max;
    logic pass_done;
  } status_t;

  function automatic logic signed [7:0] sat8(input logic signed [8:0] s);
    logic signed [7:0] r;
    if (s > 9'sd127) begin
      r = SAT_HI;
    end else if (s < -9'sd128) begin
      r = SAT_LO;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

endpackage

[hdl/ssba_regs.sv]
module ssba_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssba_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [ssba_pkg::CNT_W-1:0]   num_bins_o,
  output logic signed [7:0]            init_value_o,
  output logic signed [7:0]            min_score_o
);
  import ssba_pkg::*;

  logic [CNT_W-1:0]  num_bins_q;
  logic signed [7:0] init_value_q, min_score_q;
  logic              wr_en;
  logic [1:0]        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bins_q   <= CNT_W'(MAX_BINS);
      init_value_q <= 8'sd0;
      min_score_q  <= SAT_LO;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_NUM_BINS:   num_bins_q   <= pwdata[CNT_W-1:0];
        REG_INIT_VALUE: init_value_q <= pwdata[7:0];
        REG_MIN_SCORE:  min_score_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NUM_BINS:   prdata = {{(32-CNT_W){1'b0}}, num_bins_q};
      REG_INIT_VALUE: prdata = {{24{init_value_q[7]}}, init_value_q};
      REG_MIN_SCORE:  prdata = {{24{min_score_q[7]}}, min_score_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign num_bins_o   = num_bins_q;
  assign init_value_o = init_value_q;
  assign min_score_o  = min_score_q;

endmodule

[hdl/ssba_ctrl.sv]
module ssba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ssba_pkg::status_t sts_i,
  output ssba_pkg::cmd_t    cmd_o
);
  import ssba_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_PASS  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.clear) begin
          cmd_o.clear_bank = 1'b1;
          cmd_o.start_pass = 1'b1;
          state_d          = ST_PASS;
        end else if (sts_i.in_range) begin
          cmd_o.check_rd = 1'b1;
          state_d        = ST_CHECK;
        end else begin
          cmd_o.start_pass = 1'b1;
          state_d          = ST_PASS;
        end
      end
      ST_CHECK: begin
        cmd_o.start_pass = 1'b1;
        cmd_o.set_sub    = sts_i.at_max;
        cmd_o.set_add    = ~sts_i.at_max;
        state_d          = ST_PASS;
      end
      ST_PASS: begin
        cmd_o.pass_en = 1'b1;
        if (sts_i.pass_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/ssba_dp.sv]
module ssba_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ssba_pkg::cmd_t               cmd_i,
  output ssba_pkg::status_t            sts_o,
  input  logic [ssba_pkg::CNT_W-1:0]   num_bins_i,
  input  logic signed [7:0]            init_value_i,
  input  logic signed [7:0]            min_score_i,
  input  logic                         clear_all_i,
  input  logic [ssba_pkg::BIN_AW-1:0]  bin_index_i,
  input  logic signed [7:0]            amount_i,
  input  logic [ssba_pkg::BIN_AW-1:0]  query_index_i,
  output logic [ssba_pkg::BIN_AW-1:0]  best_bin_o,
  output logic                         best_found_o,
  output logic [7:0]                   query_value_o
);
  import ssba_pkg::*;

  // item registers
  logic                     clear_q;
  logic [BIN_AW-1:0]        idx_q, qidx_q;
  logic signed [7:0]        amt_q;
  logic [CNT_W-1:0]         count_q;
  mode_e                    mode_q;

  // bank: memory plus per-entry valid bits, invalid entries read as fill_q
  logic signed [7:0]        bank_mem [MAX_BINS];
  logic [MAX_BINS-1:0]      bank_vld_q;
  logic signed [7:0]        fill_q;
  logic signed [7:0]        rd_data_q;
  logic                     rd_vld_q;
  logic                     rd_en, wr_en;
  logic [BIN_AW-1:0]        rd_addr;

  // scan pipeline
  logic [CNT_W-1:0]         rd_cnt_q;
  logic                     issue;
  logic                     st_vld_q;
  logic [BIN_AW-1:0]        st_idx_q;
  logic signed [7:0]        cur_val, new_val;
  logic                     take;

  // running arg-max and query capture
  logic signed [7:0]        top_q;
  logic [BIN_AW-1:0]        best_q;
  logic                     found_q;
  logic [7:0]               qval_q;

  // output register
  logic [BIN_AW-1:0]        out_best_q;
  logic                     out_found_q;
  logic [7:0]               out_qval_q;

  logic [CNT_W-1:0]         count_in;

  assign count_in = (num_bins_i > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : num_bins_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      clear_q <= clear_all_i;
      idx_q   <= bin_index_i;
      amt_q   <= (amount_i == SAT_LO) ? AMT_MIN : amount_i;
      qidx_q  <= query_index_i;
      count_q <= count_in;
    end
  end

  assign issue   = cmd_i.pass_en & (rd_cnt_q < count_q);
  assign rd_en   = cmd_i.check_rd | issue;
  assign rd_addr = cmd_i.check_rd ? idx_q : rd_cnt_q[BIN_AW-1:0];
  assign wr_en   = st_vld_q & (mode_q != MODE_NONE);
  assign cur_val = rd_vld_q ? rd_data_q : fill_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= bank_mem[rd_addr];
    end
    if (wr_en) begin
      bank_mem[st_idx_q] <= new_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_vld_q <= '0;
      fill_q     <= 8'sd0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_q <= bank_vld_q[rd_addr];
      end
      if (cmd_i.clear_bank) begin
        bank_vld_q <= '0;
        fill_q     <= init_value_i;
      end else if (wr_en) begin
        bank_vld_q[st_idx_q] <= 1'b1;
      end
    end
  end

  always_comb begin
    unique case (mode_q)
      MODE_SUB: new_val = (st_idx_q != idx_q)
                          ? sat8(9'(signed'({cur_val[7], cur_val})) -
                                 9'(signed'({amt_q[7], amt_q})))
                          : cur_val;
      MODE_ADD: new_val = (st_idx_q == idx_q)
                          ? sat8(9'(signed'({cur_val[7], cur_val})) +
                                 9'(signed'({amt_q[7], amt_q})))
                          : cur_val;
      default:  new_val = cur_val;
    endcase
  end

  // floor is min_score until something qualifies, then the running top
  assign take = found_q ? (new_val >= top_q) : (new_val >= min_score_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NONE;
      rd_cnt_q <= '0;
      st_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (cmd_i.start_pass) begin
      mode_q   <= cmd_i.set_sub ? MODE_SUB : (cmd_i.set_add ? MODE_ADD : MODE_NONE);
      rd_cnt_q <= '0;
      st_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      st_vld_q <= issue;
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + CNT_W'(1);
      end
      if (st_vld_q && take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      st_idx_q <= rd_cnt_q[BIN_AW-1:0];
    end
    if (cmd_i.start_pass) begin
      top_q  <= SAT_LO;
      best_q <= '0;
      qval_q <= 8'd0;
    end else if (st_vld_q) begin
      if (take) begin
        top_q  <= new_val;
        best_q <= st_idx_q;
      end
      if (st_idx_q == qidx_q) begin
        qval_q <= new_val ^ 8'h80;
      end
    end
    if (cmd_i.load_out) begin
      out_best_q  <= best_q;
      out_found_q <= found_q;
      out_qval_q  <= qval_q;
    end
  end

  assign sts_o.clear     = clear_q;
  assign sts_o.in_range  = ({1'b0, idx_q} < count_q);
  assign sts_o.at_max    = (cur_val == SAT_HI);
  assign sts_o.pass_done = (rd_cnt_q >= count_q) & ~st_vld_q;

  assign best_bin_o    = out_best_q;
  assign best_found_o  = out_found_q;
  assign query_value_o = out_qval_q;

endmodule

[hdl/saturating_score_bins_argmax.sv]
// saturating score bins with thresholded arg-max
//
// s_axis: one request per item, tuser[0] = clear_all, tdata holds
//   bin_index, amount and query_index. m_axis: one result per request
//   with best_bin, best_found and query_value in tdata.
// apb: num_bins at 0x0, init_value at 0x4, min_score at 0x8; write only
//   while no request is in flight.
// pass: count is num_bins limited to 64; a clear or an out-of-range
//   bin_index skips the check read; each request makes a single pass over
//   the bank memory, one bin per cycle through its one read port.
// a request is held off (s_axis_tready low) while an item is in work.
// a finished result sits in an output register, so the next request is
//   taken while m_axis waits; a stalled receiver holds the result and the
//   following item waits at the end of its pass until the register frees.
// reset clears the bank to zero (valid bits), num_bins to 64,
//   init_value to 0, min_score to -128; no clearing pass is needed.
module saturating_score_bins_argmax (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // slave stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // bin_index[5:0], amount[13:6],
                                                     // query_index[19:14], zero pad
  input  logic [0:0]                  s_axis_tuser,  // clear_all[0]
  // master stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // best_bin[5:0], best_found[6],
                                                     // query_value[14:7], zero pad
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssba_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ssba_pkg::*;

  cmd_t              cmd;
  status_t           sts;
  logic [CNT_W-1:0]  num_bins;
  logic signed [7:0] init_value, min_score;
  logic [BIN_AW-1:0] best_bin;
  logic              best_found;
  logic [7:0]        query_value;

  ssba_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .num_bins_o   (num_bins),
    .init_value_o (init_value),
    .min_score_o  (min_score)
  );

  // sequencing of load, check read, bank pass and result hand-off
  ssba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // bank memory, update pass and running arg-max
  ssba_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .num_bins_i    (num_bins),
    .init_value_i  (init_value),
    .min_score_i   (min_score),
    .clear_all_i   (s_axis_tuser[0]),
    .bin_index_i   (s_axis_tdata[5:0]),
    .amount_i      (s_axis_tdata[13:6]),
    .query_index_i (s_axis_tdata[19:14]),
    .best_bin_o    (best_bin),
    .best_found_o  (best_found),
    .query_value_o (query_value)
  );

  assign m_axis_tdata = {1'b0, query_value, best_found, best_bin};

endmodule

[hdl/ssba_chk.sv]
module ssba_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // with no qualifying bin the index reads zero
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[5:0] == 6'd0)
    else $error("best_bin nonzero without best_found");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while an item is in work");

endmodule

bind saturating_score_bins_argmax ssba_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
